// ----- rtl/pfsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfsp_pkg
// shared types, constants, register map and palette of the pixel composer
// ----------------------------------------------------------------------------
package pfsp_pkg;

    localparam int unsigned DISPLAY_WIDTH_DEF = 256;
    localparam int unsigned COL_W             = 8;
    localparam int unsigned SRC_W             = 8;
    localparam int unsigned BGR_W             = 15;
    localparam int unsigned ADDR_W            = 5;
    localparam int unsigned DATA_W            = 32;
    localparam int unsigned PF_BITS           = 20;

    localparam logic [SRC_W-1:0] SRC_WIDTH = 8'd160;
    localparam logic [SRC_W-1:0] SRC_LAST  = 8'd159;
    localparam logic [SRC_W-1:0] HALF_WIDTH = 8'd80;
    localparam logic [SRC_W-1:0] POS_MASK  = 8'd159;

    typedef logic [COL_W-1:0] t_col;
    typedef logic [SRC_W-1:0] t_src;
    typedef logic [7:0]       t_colour;
    typedef logic [BGR_W-1:0] t_bgr;

    typedef enum logic [2:0] {
        REG_BACKGROUND  = 3'd0,
        REG_PF_COLOUR   = 3'd1,
        REG_PL_COLOURS  = 3'd2,
        REG_PF_PATTERN  = 3'd3,
        REG_PF_MIRROR   = 3'd4,
        REG_PL_GRAPHICS = 3'd5,
        REG_PL0_POS     = 3'd6,
        REG_PL1_POS     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_colour              background_colour;
        t_colour              playfield_colour;
        logic [15:0]          player_colours;
        logic [PF_BITS-1:0]   playfield_pattern;
        logic                 playfield_mirror;
        logic [15:0]          player_graphics;
        logic [7:0]           player0_position;
        logic [7:0]           player1_position;
    } t_cfg;

    function automatic t_bgr c15(input logic [4:0] r, input logic [4:0] g,
                                 input logic [4:0] b);
        return {b, g, r};
    endfunction

    // one player's coverage of source pixel src, leftmost pixel from bit 7
    function automatic logic player_hit(input logic [7:0] pattern,
                                        input logic [7:0] position,
                                        input t_src src);
        logic [7:0] left;
        logic [7:0] off;
        left = position & POS_MASK;
        off  = src - left;
        return (src >= left) && (src < SRC_WIDTH) && (off < 8'd8)
               && pattern[3'd7 - off[2:0]];
    endfunction

    localparam t_bgr PALETTE [0:127] = '{
        c15( 0, 0, 0), c15( 4, 4, 4), c15( 8, 8, 8), c15(12,12,12),
        c15(16,16,16), c15(20,20,20), c15(24,24,24), c15(28,28,28),
        c15(16, 8, 0), c15(20,12, 0), c15(24,16, 0), c15(28,20, 0),
        c15(31,24, 4), c15(31,26, 8), c15(31,28,12), c15(31,30,16),
        c15(20, 4, 0), c15(24, 8, 0), c15(28,12, 0), c15(31,16, 0),
        c15(31,20, 4), c15(31,22, 8), c15(31,24,12), c15(31,26,16),
        c15(20, 0, 0), c15(24, 4, 0), c15(28, 8, 0), c15(31,12, 0),
        c15(31,16, 0), c15(31,18, 4), c15(31,20, 8), c15(31,22,12),
        c15(18, 0, 8), c15(22, 4,12), c15(26, 8,16), c15(30,12,20),
        c15(31,16,24), c15(31,20,26), c15(31,22,28), c15(31,24,30),
        c15(12, 0,18), c15(16, 0,22), c15(20, 4,26), c15(24, 8,30),
        c15(28,12,31), c15(30,16,31), c15(31,20,31), c15(31,24,31),
        c15( 4, 0,20), c15( 8, 0,24), c15(12, 4,28), c15(16, 8,31),
        c15(20,12,31), c15(24,16,31), c15(28,20,31), c15(31,24,31),
        c15( 0, 0,20), c15( 0, 4,24), c15( 4, 8,28), c15( 8,12,31),
        c15(12,16,31), c15(16,20,31), c15(20,24,31), c15(24,28,31),
        c15( 0, 8,20), c15( 0,12,24), c15( 4,16,28), c15( 8,20,31),
        c15(12,24,31), c15(16,28,31), c15(20,30,31), c15(24,31,31),
        c15( 0,14,14), c15( 0,18,18), c15( 4,22,22), c15( 8,26,26),
        c15(12,30,30), c15(16,31,31), c15(20,31,31), c15(24,31,31),
        c15( 0,16, 8), c15( 0,20,12), c15( 4,24,16), c15( 8,28,20),
        c15(12,31,24), c15(16,31,26), c15(20,31,28), c15(24,31,30),
        c15( 0,16, 0), c15( 0,20, 0), c15( 4,24, 4), c15( 8,28, 8),
        c15(12,31,12), c15(16,31,16), c15(20,31,20), c15(24,31,24),
        c15( 8,16, 0), c15(12,20, 0), c15(16,24, 4), c15(20,28, 8),
        c15(24,31,12), c15(26,31,16), c15(28,31,20), c15(30,31,24),
        c15(16,14, 0), c15(20,18, 0), c15(24,22, 0), c15(28,26, 0),
        c15(31,30, 4), c15(31,31, 8), c15(31,31,12), c15(31,31,16),
        c15(22,10, 0), c15(26,14, 0), c15(30,18, 0), c15(31,22, 4),
        c15(31,26, 8), c15(31,28,12), c15(31,30,16), c15(31,31,20),
        c15(28,28,28), c15(29,29,29), c15(30,30,30), c15(31,31,31),
        c15(31,31,31), c15(31,31,31), c15(31,31,31), c15(31,31,31)
    };

endpackage
`default_nettype wire

// ----- rtl/playfield_sprite_pixel_composer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// playfield_sprite_pixel_composer
// scales a display column onto the 160-pixel source line, composes the
// playfield and two players, and outputs the pixel as bgr555
// ----------------------------------------------------------------------------
// usage:
//   - input channel: drive start high with i_display_column; the word is
//     taken at every edge where start is high and busy is low
//   - busy is low whenever reset is released, so a column can enter on
//     every clock: one pixel per cycle sustained
//   - output channel: o_done marks o_pixel_colour for exactly one cycle,
//     after the column has passed three scaler stages, one compose stage
//     and one palette stage; the receiver cannot stall and words come out
//     in input order
//   - configuration: apb-style port, registers at byte address 4*index;
//     pready is tied high, writes land on psel & penable & pwrite; write
//     only while no pixel is in flight
//   - reset (synchronous, active low): clears all configuration registers
//     and drops every in-flight word; busy is high while reset is held
// ----------------------------------------------------------------------------
module playfield_sprite_pixel_composer #(
    parameter int unsigned DISPLAY_WIDTH = pfsp_pkg::DISPLAY_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // pixel request
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [pfsp_pkg::COL_W-1:0]  i_display_column,
    // pixel result
    output logic                             o_done,
    output logic      [pfsp_pkg::BGR_W-1:0]  o_pixel_colour,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pfsp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pfsp_pkg::DATA_W-1:0] pwdata,
    output logic      [pfsp_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import pfsp_pkg::*;

    t_cfg    w_cfg;
    logic    w_accept;
    logic    w_src_vld;
    t_src    w_src;
    logic    w_col_vld;
    t_colour w_colour;

    // no back pressure once out of reset
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    pfsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // stages 1..3: column * 160 / DISPLAY_WIDTH, saturated at 159
    pfsp_scaler #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH)
    ) u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_col   (i_display_column),
        .o_valid (w_src_vld),
        .o_src   (w_src)
    );

    // stage 4: background, playfield, player 0, player 1 priority
    pfsp_compose u_compose (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_src_vld),
        .i_src    (w_src),
        .i_cfg    (w_cfg),
        .o_valid  (w_col_vld),
        .o_colour (w_colour)
    );

    // stage 5: palette lookup into the output register
    pfsp_palette u_palette (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_col_vld),
        .i_colour (w_colour),
        .o_valid  (o_done),
        .o_bgr    (o_pixel_colour)
    );

endmodule
`default_nettype wire

// ----- rtl/pfsp_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfsp_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module pfsp_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pfsp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pfsp_pkg::DATA_W-1:0] pwdata,
    output logic      [pfsp_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output pfsp_pkg::t_cfg                   o_cfg
);
    import pfsp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_BACKGROUND:  n_cfg.background_colour = pwdata[7:0];
                REG_PF_COLOUR:   n_cfg.playfield_colour  = pwdata[7:0];
                REG_PL_COLOURS:  n_cfg.player_colours    = pwdata[15:0];
                REG_PF_PATTERN:  n_cfg.playfield_pattern = pwdata[PF_BITS-1:0];
                REG_PF_MIRROR:   n_cfg.playfield_mirror  = pwdata[0];
                REG_PL_GRAPHICS: n_cfg.player_graphics   = pwdata[15:0];
                REG_PL0_POS:     n_cfg.player0_position  = pwdata[7:0];
                REG_PL1_POS:     n_cfg.player1_position  = pwdata[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_BACKGROUND:  prdata = DATA_W'(r_cfg.background_colour);
            REG_PF_COLOUR:   prdata = DATA_W'(r_cfg.playfield_colour);
            REG_PL_COLOURS:  prdata = DATA_W'(r_cfg.player_colours);
            REG_PF_PATTERN:  prdata = DATA_W'(r_cfg.playfield_pattern);
            REG_PF_MIRROR:   prdata = DATA_W'(r_cfg.playfield_mirror);
            REG_PL_GRAPHICS: prdata = DATA_W'(r_cfg.player_graphics);
            REG_PL0_POS:     prdata = DATA_W'(r_cfg.player0_position);
            REG_PL1_POS:     prdata = DATA_W'(r_cfg.player1_position);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- rtl/pfsp_scaler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfsp_scaler
// three-stage column to source pixel scaler, reciprocal multiply
// ----------------------------------------------------------------------------
module pfsp_scaler #(
    parameter int unsigned DISPLAY_WIDTH = pfsp_pkg::DISPLAY_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire pfsp_pkg::t_col i_col,
    output logic                o_valid,
    output pfsp_pkg::t_src      o_src
);
    import pfsp_pkg::*;

    // floor(n / DISPLAY_WIDTH) == (n * ceil(2^K / DISPLAY_WIDTH)) >> K for n < 2^16
    localparam int unsigned  K       = 32;
    localparam int unsigned  NUM_W   = 16;
    localparam longint unsigned RECIP = ((64'd1 << K) + DISPLAY_WIDTH - 1) / DISPLAY_WIDTH;
    localparam int unsigned  RECIP_W = $clog2(RECIP + 1);
    localparam int unsigned  PROD_W  = NUM_W + RECIP_W;
    localparam int unsigned  RAW_W   = PROD_W - K;

    logic [NUM_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;
    t_src              r_src;
    logic [2:0]        r_vld;
    logic [RAW_W-1:0]  w_raw;

    assign w_raw = r_prod[PROD_W-1:K];

    always_ff @(posedge i_clk) begin
        r_num  <= NUM_W'(i_col) * NUM_W'(SRC_WIDTH);
        r_prod <= PROD_W'(r_num) * PROD_W'(RECIP);
        r_src  <= (w_raw > RAW_W'(SRC_LAST)) ? SRC_LAST : w_raw[SRC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];
    assign o_src   = r_src;

endmodule
`default_nettype wire

// ----- rtl/pfsp_compose.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfsp_compose
// playfield and player priority select, one register stage
// ----------------------------------------------------------------------------
module pfsp_compose (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire pfsp_pkg::t_src    i_src,
    input  wire pfsp_pkg::t_cfg    i_cfg,
    output logic                   o_valid,
    output pfsp_pkg::t_colour      o_colour
);
    import pfsp_pkg::*;

    t_src       w_pfx;
    logic [4:0] w_pf_idx;
    t_colour    n_colour;
    t_colour    r_colour;
    logic       r_vld;

    always_comb begin
        if (i_src < HALF_WIDTH) begin
            w_pfx = i_src;
        end else if (i_cfg.playfield_mirror) begin
            w_pfx = SRC_LAST - i_src;
        end else begin
            w_pfx = i_src - HALF_WIDTH;
        end
        w_pf_idx = w_pfx[6:2];

        n_colour = i_cfg.background_colour;
        if (i_cfg.playfield_pattern[w_pf_idx]) begin
            n_colour = i_cfg.playfield_colour;
        end
        // player 1 over player 0
        if (player_hit(i_cfg.player_graphics[7:0], i_cfg.player0_position, i_src)) begin
            n_colour = i_cfg.player_colours[7:0];
        end
        if (player_hit(i_cfg.player_graphics[15:8], i_cfg.player1_position, i_src)) begin
            n_colour = i_cfg.player_colours[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_colour <= n_colour;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    assign o_valid  = r_vld;
    assign o_colour = r_colour;

endmodule
`default_nettype wire

// ----- rtl/pfsp_palette.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfsp_palette
// colour byte to bgr555 lookup, registered output
// ----------------------------------------------------------------------------
module pfsp_palette (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire pfsp_pkg::t_colour i_colour,
    output logic                   o_valid,
    output pfsp_pkg::t_bgr         o_bgr
);
    import pfsp_pkg::*;

    t_bgr r_bgr;
    logic r_vld;

    always_ff @(posedge i_clk) begin
        r_bgr <= PALETTE[i_colour[7:1]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    assign o_valid = r_vld;
    assign o_bgr   = r_bgr;

endmodule
`default_nettype wire

// ----- rtl/pfsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfsp_checker
// port-level checks on latency, spurious pixels, back pressure and output consistency
// ----------------------------------------------------------------------------
module pfsp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic [pfsp_pkg::COL_W-1:0]  i_display_column,
    input wire logic                        o_done,
    input wire logic [pfsp_pkg::BGR_W-1:0]  o_pixel_colour,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic                        pready
);
    logic w_acc;
    logic w_wr;

    assign w_acc = start && !busy;
    assign w_wr  = psel && penable && pwrite && pready;

    // every accepted column gives a pixel after the scaler, compose and palette stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##5 o_done)
        else $error("missing pixel five cycles after accept");

    // no pixel without a matching accepted column
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, 5))
        else $error("pixel without matching request");

    // back to back: a column can be taken in every cycle out of reset
    a_no_stall: assert property (@(posedge i_clk)
        i_rst_n |-> !busy)
        else $error("busy raised outside reset");

    // same column twice in a row with quiet configuration gives the same pixel
    a_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done)
         && ($past(i_display_column, 5) == $past(i_display_column, 6))
         && !$past(w_wr, 1) && !$past(w_wr, 2) && !$past(w_wr, 3)
         && !$past(w_wr, 4) && !$past(w_wr, 5) && !$past(w_wr, 6)
         && !$past(w_wr, 7))
        |-> $stable(o_pixel_colour))
        else $error("pixel differs for repeated column");

endmodule

bind playfield_sprite_pixel_composer pfsp_checker u_pfsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_display_column (i_display_column),
    .o_done           (o_done),
    .o_pixel_colour   (o_pixel_colour),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready)
);
`default_nettype wire
